// ----- src/fat_pkg.sv -----
// shared types and constants of the filtered adc thermostat
`default_nettype none

package fat_pkg;

	localparam int SampleW = 12;
	localparam int MeanW   = 12;
	localparam int RunW    = 2;
	localparam int CountW  = 4;
	localparam int TempW   = 8;
	localparam int LimitW  = 7;
	localparam int CfgIdxW = 1;

	localparam logic [SampleW:0]  Window      = 13'd10;
	localparam logic [RunW-1:0]   MaxOutliers = 2'd3;
	localparam logic signed [TempW-1:0] TempOffset = 8'sd77;

	// 12/458 = 6/229 ~ 36632*6 / 2^23, exact floor for every 12-bit mean
	localparam int RecipW     = 18;
	localparam logic [RecipW-1:0] TempRecip = 18'd219792;
	localparam int TempShift  = 23;
	localparam int ProdW      = MeanW + RecipW;
	localparam int QuotW      = 7;

	localparam logic [LimitW-1:0] HighReset = 7'd55;
	localparam logic [LimitW-1:0] LowReset  = 7'd45;

	localparam logic [CfgIdxW-1:0] CfgHighLimit = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgLowLimit  = 1'd1;

	typedef struct packed {
		logic               we;
		logic [CfgIdxW-1:0] index;
		logic [LimitW-1:0]  data;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [MeanW-1:0] mean;
	} mean_beat_t;

	typedef struct packed {
		logic                    valid;
		logic signed [TempW-1:0] temp;
	} temp_beat_t;

endpackage

`default_nettype wire

// ----- src/fat_if.sv -----
// stream interfaces for samples and thermostat results
`default_nettype none

interface fat_sample_if;
	logic                          valid;
	logic                          ready;
	logic [fat_pkg::SampleW-1:0]   sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface fat_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [fat_pkg::TempW-1:0]  temperature;
	logic                              relay_on;
	logic                              temp_changed;

	modport source (output valid, output temperature, output relay_on,
		output temp_changed, input ready);
	modport sink (input valid, input temperature, input relay_on,
		input temp_changed, output ready);
endinterface

`default_nettype wire

// ----- src/fat_filter.sv -----
// sample register, outlier rejecting running mean and update counter
`default_nettype none

module fat_filter #(
	parameter int SAMPLES_PER_UPDATE = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	fat_sample_if.sink               samples,
	output fat_pkg::mean_beat_t      mean_out,
	input  wire logic                mean_ready
);

	logic                          v_s1;
	logic [fat_pkg::SampleW-1:0]   sample_s1;
	logic [fat_pkg::MeanW-1:0]     mean_q;
	logic [fat_pkg::RunW-1:0]      run_q;
	logic [fat_pkg::CountW-1:0]    count_q;
	logic                          mean_v_s2;
	logic [fat_pkg::MeanW-1:0]     mean_s2;

	logic [fat_pkg::SampleW:0]     s_ext;
	logic [fat_pkg::SampleW:0]     m_ext;
	logic                          accept;
	logic [fat_pkg::SampleW:0]     sum;
	logic [fat_pkg::MeanW-1:0]     mean_next;
	logic [fat_pkg::CountW-1:0]    count_inc;
	logic                          eval;
	logic                          s2_ready;
	logic                          fire_s1;

	assign s_ext     = {1'b0, sample_s1};
	assign m_ext     = {1'b0, mean_q};
	assign accept    = (mean_q == '0) || (run_q == fat_pkg::MaxOutliers) ||
		((s_ext + fat_pkg::Window >= m_ext) && (s_ext <= m_ext + fat_pkg::Window));
	assign sum       = s_ext + m_ext;
	assign mean_next = accept ? sum[fat_pkg::SampleW:1] : mean_q;
	assign count_inc = count_q + 1'b1;
	assign eval      = count_inc >= fat_pkg::CountW'(SAMPLES_PER_UPDATE);

	assign s2_ready       = !mean_v_s2 || mean_ready;
	assign fire_s1        = v_s1 && (!eval || s2_ready);
	assign samples.ready  = !v_s1 || fire_s1;
	assign mean_out.valid = mean_v_s2;
	assign mean_out.mean  = mean_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			mean_q    <= '0;
			run_q     <= '0;
			count_q   <= '0;
			mean_v_s2 <= 1'b0;
		end else begin
			if (samples.ready)
				v_s1 <= samples.valid;
			if (fire_s1) begin
				mean_q  <= mean_next;
				run_q   <= accept ? '0 : run_q + 1'b1;
				count_q <= eval ? '0 : count_inc;
			end
			if (s2_ready)
				mean_v_s2 <= fire_s1 && eval;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid)
			sample_s1 <= samples.sample;
		if (s2_ready && fire_s1 && eval)
			mean_s2 <= mean_next;
	end

endmodule

`default_nettype wire

// ----- src/fat_convert.sv -----
// mean to degrees conversion by reciprocal multiply
`default_nettype none

module fat_convert (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  fat_pkg::mean_beat_t      mean_in,
	output logic                     mean_ready,
	output fat_pkg::temp_beat_t      temp_out,
	input  wire logic                temp_ready
);

	logic [fat_pkg::ProdW-1:0]           prod;
	logic [fat_pkg::QuotW-1:0]           quot;
	logic signed [fat_pkg::TempW-1:0]    temp;
	logic                                temp_v_s3;
	logic signed [fat_pkg::TempW-1:0]    temp_s3;

	assign prod = fat_pkg::ProdW'(mean_in.mean) * fat_pkg::ProdW'(fat_pkg::TempRecip);
	assign quot = prod[fat_pkg::TempShift +: fat_pkg::QuotW];
	assign temp = fat_pkg::TempOffset - signed'({1'b0, quot});

	assign mean_ready     = !temp_v_s3 || temp_ready;
	assign temp_out.valid = temp_v_s3;
	assign temp_out.temp  = temp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_v_s3 <= 1'b0;
		end else if (mean_ready) begin
			temp_v_s3 <= mean_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mean_ready && mean_in.valid)
			temp_s3 <= temp;
	end

endmodule

`default_nettype wire

// ----- src/fat_ctrl.sv -----
// limit registers, hysteresis relay control and result register
`default_nettype none

module fat_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  fat_pkg::cfg_t            cfg,
	input  fat_pkg::temp_beat_t      temp_in,
	output logic                     temp_ready,
	fat_result_if.source             results
);

	logic [fat_pkg::LimitW-1:0]          high_q;
	logic [fat_pkg::LimitW-1:0]          low_q;
	logic                                relay_q;
	logic signed [fat_pkg::TempW-1:0]    last_q;
	logic                                out_valid_q;

	logic signed [fat_pkg::TempW-1:0]    high_s;
	logic signed [fat_pkg::TempW-1:0]    low_s;
	logic                                relay_next;
	logic                                fire;

	assign high_s = signed'({1'b0, high_q});
	assign low_s  = signed'({1'b0, low_q});

	always_comb begin
		relay_next = relay_q;
		if (!relay_q && temp_in.temp <= low_s)
			relay_next = 1'b1;
		if (temp_in.temp >= high_s)
			relay_next = 1'b0;
	end

	assign temp_ready    = !out_valid_q || results.ready;
	assign fire          = temp_in.valid && temp_ready;
	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q      <= fat_pkg::HighReset;
			low_q       <= fat_pkg::LowReset;
			relay_q     <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (temp_ready)
				out_valid_q <= temp_in.valid;
			if (fire) begin
				relay_q <= relay_next;
				last_q  <= temp_in.temp;
			end
			if (cfg.we) begin
				case (cfg.index)
					fat_pkg::CfgHighLimit: begin
						high_q  <= cfg.data;
						relay_q <= 1'b0;
					end
					fat_pkg::CfgLowLimit: begin
						low_q   <= cfg.data;
						relay_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			results.temperature  <= temp_in.temp;
			results.relay_on     <= relay_next;
			results.temp_changed <= temp_in.temp != last_q;
		end
	end

endmodule

`default_nettype wire

// ----- src/filtered_adc_thermostat.sv -----
// Filtered ADC thermostat. Takes one 12-bit sample per cycle, a rate set by
// the registered mean and outlier update loop; the input stalls only when the
// sample that completes a period finds the pipeline stages full behind a
// result that waits at the output. A sample is folded into a running mean
// unless it is an outlier following fewer than MaxOutliers outliers, and
// every SAMPLES_PER_UPDATE samples the mean is converted to degrees and drives
// a hysteresis relay. A result passes the sample register, mean update,
// conversion multiply and result register after the period-completing sample
// is accepted. Limit writes also switch the relay off and are meant for an idle block.
`default_nettype none

module filtered_adc_thermostat #(
	parameter int SAMPLES_PER_UPDATE = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	fat_sample_if.sink                           samples,
	fat_result_if.source                         results,
	input  wire logic                            cfg_we,
	input  wire logic [fat_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [fat_pkg::LimitW-1:0]      cfg_data
);

	fat_pkg::mean_beat_t  mean_beat;
	logic                 mean_ready;
	fat_pkg::temp_beat_t  temp_beat;
	logic                 temp_ready;
	fat_pkg::cfg_t        cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	fat_filter #(
		.SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE)
	) u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.mean_out   (mean_beat),
		.mean_ready (mean_ready)
	);

	fat_convert u_convert (
		.clk        (clk),
		.arst_n     (arst_n),
		.mean_in    (mean_beat),
		.mean_ready (mean_ready),
		.temp_out   (temp_beat),
		.temp_ready (temp_ready)
	);

	fat_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.temp_in    (temp_beat),
		.temp_ready (temp_ready),
		.results    (results)
	);

endmodule

`default_nettype wire
